FILE: hdl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Each macro expands to one labeled concurrent assertion clocked on clk,
// disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check: prop must hold at every clock edge out of reset.
`define SWTD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be true at a clock edge out of reset.
`define SWTD_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: hdl/swtd_pkg.sv
// Package for the sliding window token decoder: request types, sequencer
// states and shared constants. No dependencies.
package swtd_pkg;

	localparam int WINDOW_DEF = 12;
	localparam int POS_W      = 4;
	localparam int LEN_W      = 4;

	// longest copy run per token; larger length digits saturate here
	localparam logic [LEN_W-1:0] MAX_COPY = 4'd9;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic [LEN_W-1:0] copy_length;
		logic [7:0]       literal;
	} token_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_COPY = 2'd1,
		ST_LIT  = 2'd2
	} state_t;

endpackage

FILE: hdl/sliding_window_token_decoder.sv
// Sliding window token decoder, top level.
// Sequencer, output register and history pointer; uses swtd_pkg,
// swtd_addr, swtd_hist and assert_macros.svh.
//
// Usage:
//   token channel (token_valid/token_stall/token): one request per token,
//   holding a position digit, a copy length digit and a literal byte.
//   result channel (result_valid/result_stall/result): one request per
//   decoded byte; copied bytes first with last = 0, then the literal with
//   last = 1.
//   A token with nonzero position and length copies min(length, 9) bytes
//   from Window - position bytes back in the history, copies may overlap.
//   The first byte goes through the history read register, then, once the
//   result channel is free, into the output register. Throughput: one byte
//   per cycle while result_stall is low; each token (n copied bytes, n up to 9)
//   is done before the next is taken; the single history read port and its
//   registered read set the pace. token_stall is high while a token is being decoded.
//   A result stall holds the sequencer at its next byte (a token may still
//   be taken while idle); the held result does not change.
//   Reset: the history reads as zeros until written; the output register is emptied.
`include "assert_macros.svh"

module sliding_window_token_decoder #(
	parameter int Window = swtd_pkg::WINDOW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              token_valid,
	output logic              token_stall,
	input  swtd_pkg::token_t  token,
	output logic              result_valid,
	input  logic              result_stall,
	output swtd_pkg::result_t result
);
	import swtd_pkg::*;

	localparam int PW = $clog2(Window);

	state_t          st_q, st_nxt;
	logic [PW-1:0]   ptr_q;
	logic            full_q;
	logic [POS_W-1:0] pos_q;
	logic [LEN_W-1:0] left_q;
	logic [7:0]      lit_q;
	logic            rd_zero_q, rd_byp_q;
	logic [7:0]      byp_q;
	result_t         out_q;
	logic            out_vld_q;

	logic            free, acc, do_copy, emit, emit_last;
	logic            rd_en, we, byp;
	logic [7:0]      wdata, rd_data, copy_byte;
	logic [PW-1:0]   ptr_inc, unit_base, unit_addr;
	logic            full_inc, unit_full, unit_zero;
	logic [POS_W-1:0] unit_pos;
	logic [LEN_W-1:0] len_sat;

	// pointer arithmetic
	always_comb begin
		ptr_inc  = (ptr_q == PW'(Window - 1)) ? '0 : ptr_q + 1'b1;
		full_inc = full_q || (ptr_q == PW'(Window - 1));
		len_sat  = (token.copy_length > MAX_COPY) ? MAX_COPY : token.copy_length;
		do_copy  = (token.position != '0) && (token.copy_length != '0);
		free     = !out_vld_q || !result_stall;
	end

	// address unit operands: at accept the pointer is as is, during a copy
	// the next read is issued in the same cycle as this byte's write
	always_comb begin
		unit_base = (st_q == ST_IDLE) ? ptr_q : ptr_inc;
		unit_full = (st_q == ST_IDLE) ? full_q : full_inc;
		unit_pos  = (st_q == ST_IDLE) ? token.position : pos_q;
	end

	swtd_addr #(.Window(Window)) u_addr (
		.base     (unit_base),
		.full     (unit_full),
		.position (unit_pos),
		.addr     (unit_addr),
		.zero     (unit_zero)
	);

	// source equal to the entry written now: the memory read is stale
	assign byp = (st_q != ST_IDLE) && (unit_addr == ptr_q);

	assign copy_byte = rd_zero_q ? 8'd0 : (rd_byp_q ? byp_q : rd_data);

	swtd_hist #(.Window(Window)) u_hist (
		.clk   (clk),
		.we    (we),
		.waddr (ptr_q),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (unit_addr),
		.rdata (rd_data)
	);

	// sequencer outputs
	always_comb begin
		token_stall = 1'b1;
		acc         = 1'b0;
		rd_en       = 1'b0;
		we          = 1'b0;
		emit        = 1'b0;
		emit_last   = 1'b0;
		wdata       = lit_q;
		unique case (st_q)
			ST_IDLE: begin
				token_stall = 1'b0;
				acc         = token_valid;
				rd_en       = token_valid && do_copy;
			end
			ST_COPY: begin
				wdata = copy_byte;
				if (free) begin
					emit  = 1'b1;
					we    = 1'b1;
					rd_en = (left_q != LEN_W'(1));
				end
			end
			ST_LIT: begin
				if (free) begin
					emit      = 1'b1;
					we        = 1'b1;
					emit_last = 1'b1;
				end
			end
			default: begin
				token_stall = 1'b1;
			end
		endcase
	end

	// sequencer next state
	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (token_valid) begin
					st_nxt = do_copy ? ST_COPY : ST_LIT;
				end
			end
			ST_COPY: begin
				if (free && (left_q == LEN_W'(1))) begin
					st_nxt = ST_LIT;
				end
			end
			ST_LIT: begin
				if (free) begin
					st_nxt = ST_IDLE;
				end
			end
			default: begin
				st_nxt = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			ptr_q     <= '0;
			full_q    <= 1'b0;
			left_q    <= '0;
			out_vld_q <= 1'b0;
			rd_zero_q <= 1'b0;
			rd_byp_q  <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (we) begin
				ptr_q  <= ptr_inc;
				full_q <= full_inc;
			end
			if (acc) begin
				left_q <= len_sat;
			end else if (emit && !emit_last) begin
				left_q <= left_q - 1'b1;
			end
			if (rd_en) begin
				rd_zero_q <= unit_zero;
				rd_byp_q  <= byp;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (!result_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			pos_q <= token.position;
			lit_q <= token.literal;
		end
		if (rd_en) begin
			byp_q <= wdata;
		end
		if (emit) begin
			out_q.out_byte <= wdata;
			out_q.last     <= emit_last;
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

	// checks
	`SWTD_ASSERT(a_copy_len, (st_q == ST_COPY) |-> ((left_q != '0) && (left_q <= MAX_COPY)), "copy count out of range")
	`SWTD_ASSERT(a_full_wrap, $rose(full_q) |-> (ptr_q == '0), "history filled without pointer wrap")
	`SWTD_NEVER(a_ptr_range, ({1'b0, ptr_q} >= (PW + 1)'(Window)), "write pointer beyond window")

endmodule

FILE: hdl/swtd_hist.sv
// History memory: one write port and one registered read port.
// Depends on nothing but its Window parameter.
module swtd_hist #(
	parameter int Window = 12
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [$clog2(Window)-1:0] waddr,
	input  logic [7:0]                wdata,
	input  logic                      re,
	input  logic [$clog2(Window)-1:0] raddr,
	output logic [7:0]                rdata
);

	logic [7:0] mem [Window];
	logic [7:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data valid the cycle after re
	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	assign rdata = rd_data_q;

endmodule

FILE: hdl/swtd_addr.sv
// Shared address unit: history index of the copy source, wrapped modulo
// Window, plus a flag for sources that were never written. Uses swtd_pkg.
module swtd_addr #(
	parameter int Window = 12
) (
	input  logic [$clog2(Window)-1:0] base,
	input  logic                      full,
	input  logic [swtd_pkg::POS_W-1:0] position,
	output logic [$clog2(Window)-1:0] addr,
	output logic                      zero
);
	import swtd_pkg::*;

	localparam int PW = $clog2(Window);
	localparam int SW = PW + 1;

	logic [SW-1:0] sum;
	logic [SW-1:0] wrapped;
	logic          beyond;

	// one add, one compare-subtract for the wrap
	always_comb begin
		sum     = SW'(base) + SW'(position);
		wrapped = (sum >= SW'(Window)) ? sum - SW'(Window) : sum;
		beyond  = SW'(position) >= SW'(Window);
		addr    = beyond ? '0 : wrapped[PW-1:0];
		// before the first wrap only entries below the write pointer hold data
		zero    = beyond || (!full && (addr >= base));
	end

endmodule

FILE: dv/testbench.sv
// Testbench for sliding_window_token_decoder: a directed token table, then random tokens.
// A window model predicts each byte not typed in. Depends on swtd_pkg and the RTL top level.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import swtd_pkg::*;

	localparam int WIN        = WINDOW_DEF;
	localparam int N_RANDOM   = 158;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYC  = 20;

	typedef struct {
		token_t     tok;
		bit         known;   // expectation typed in below
		int         ncopy;   // copied bytes expected when known
		logic [7:0] fill;    // value of every copied byte when known
	} token_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    token_valid = 1'b0;
	logic    token_stall;
	token_t  token = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// window model state
	logic [7:0] win_mem [WIN];
	int         win_ptr;

	result_t    bytes_due [$];
	token_row_t token_table [$];
	int         mismatches = 0;
	int         idle_cycles = 0;
	int         burst_left = 0;
	logic [7:0] stall_phase = '0;

	sliding_window_token_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token        (token),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decode one token against the window model; copies may overlap their own output.
	function automatic void decode_token(input token_t t, ref result_t outs[$]);
		logic [3:0] run;
		logic [7:0] b;
		run = (t.copy_length > MAX_COPY) ? MAX_COPY : t.copy_length;
		if (t.position != '0 && run != '0) begin
			for (int k = 0; k < run; k++) begin
				// distance WIN - position back; position at or past WIN reads zero
				if (int'(t.position) >= WIN)
					b = 8'h00;
				else
					b = win_mem[(win_ptr + int'(t.position)) % WIN];
				win_mem[win_ptr] = b;
				win_ptr = (win_ptr + 1) % WIN;
				outs.push_back('{out_byte: b, last: 1'b0});
			end
		end
		win_mem[win_ptr] = t.literal;
		win_ptr = (win_ptr + 1) % WIN;
		outs.push_back('{out_byte: t.literal, last: 1'b1});
	endfunction

	function automatic void add_row(input int p, input int l, input int lit, input bit known,
			input int ncopy, input int fill);
		token_row_t r;
		r.tok.position    = p[3:0];
		r.tok.copy_length = l[3:0];
		r.tok.literal     = lit[7:0];
		r.known = known;
		r.ncopy = ncopy;
		r.fill  = fill[7:0];
		token_table.push_back(r);
	endfunction

	function automatic void report(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0h, got %0h", what, want, got);
	endfunction

	// Present one token request, wait for acceptance, queue its bytes, then pace the burst.
	task automatic send_token(input token_t t, input bit known, input int ncopy,
			input logic [7:0] fill);
		result_t outs[$];
		int gap;
		token_valid <= 1'b1;
		token <= t;
		@(posedge clk);
		while (token_stall) @(posedge clk);
		decode_token(t, outs);
		if (known) begin
			for (int k = 0; k < ncopy; k++)
				bytes_due.push_back('{out_byte: fill, last: 1'b0});
			bytes_due.push_back('{out_byte: t.literal, last: 1'b1});
		end else begin
			foreach (outs[i]) bytes_due.push_back(outs[i]);
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				token_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Result side stalls: quiet, light, heavy and periodic phases, chosen by the top two bits of stall_phase.
	always @(posedge clk) begin
		stall_phase <= stall_phase + 8'd1;
		case (stall_phase[7:6])
			2'd0: result_stall <= 1'b0;
			2'd1: result_stall <= ($urandom_range(0, 3) == 0);
			2'd2: result_stall <= ($urandom_range(0, 9) < 6);
			default: result_stall <= (stall_phase[1:0] == 2'b11);
		endcase
	end

	// Check each accepted byte against the oldest expectation; watchdog on idle cycles.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if ((result_valid && !result_stall) || (token_valid && !token_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (result_valid && !result_stall) begin
				if (bytes_due.size() == 0) begin
					report("unexpected byte", 0, result.out_byte);
				end else begin
					want = bytes_due.pop_front();
					if (result.out_byte !== want.out_byte)
						report("out_byte", want.out_byte, result.out_byte);
					if (result.last !== want.last)
						report("last", want.last, result.last);
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		token_t t;
		int sel;
		int p;
		int l;
		foreach (win_mem[i]) win_mem[i] = 8'h00;
		win_ptr = 0;

		// position, length, literal, known, copies, copy value
		add_row( 5,  3, 8'hAA, 1, 3, 8'h00);  // fresh window reads zeros
		add_row( 0,  9, 8'h00, 1, 0, 8'h00);  // zero position: literal only
		add_row( 9,  0, 8'hFF, 1, 0, 8'h00);  // zero length: literal only
		add_row(15, 15, 8'h55, 1, 9, 8'h00);  // past window, length saturates
		add_row(12,  1, 8'h01, 1, 1, 8'h00);  // distance zero
		add_row( 0,  0, 8'h11, 0, 0, 8'h00);
		add_row( 0,  0, 8'h22, 0, 0, 8'h00);
		add_row( 0,  0, 8'h33, 0, 0, 8'h00);
		add_row(11,  9, 8'h44, 0, 0, 8'h00);  // distance one, full overlap
		add_row(10, 10, 8'h66, 0, 0, 8'h00);
		add_row( 1,  9, 8'h77, 0, 0, 8'h00);  // longest distance
		add_row( 9,  4, 8'h88, 0, 0, 8'h00);
		add_row( 6,  6, 8'h99, 0, 0, 8'h00);
		add_row( 3, 15, 8'h80, 0, 0, 8'h00);
		add_row( 2,  1, 8'h7F, 0, 0, 8'h00);
		add_row(13,  2, 8'hC3, 1, 2, 8'h00);
		add_row(14,  8, 8'h3C, 1, 8, 8'h00);
		add_row(11, 12, 8'hE7, 0, 0, 8'h00);
		add_row( 8,  5, 8'h5A, 0, 0, 8'h00);
		add_row( 4,  7, 8'hA5, 0, 0, 8'h00);
		add_row( 7,  3, 8'h00, 0, 0, 8'h00);
		add_row( 0, 15, 8'hFF, 1, 0, 8'h00);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (token_table[i])
			send_token(token_table[i].tok, token_table[i].known, token_table[i].ncopy,
				token_table[i].fill);

		// Mostly in-window copies; some out-of-window, oversize and zero-digit tokens.
		repeat (N_RANDOM) begin
			sel = $urandom_range(0, 99);
			if (sel < 75) begin
				p = $urandom_range(1, 11);
				l = $urandom_range(1, 9);
			end else if (sel < 85) begin
				p = $urandom_range(12, 15);
				l = $urandom_range(0, 15);
			end else if (sel < 92) begin
				p = $urandom_range(0, 15);
				l = $urandom_range(10, 15);
			end else if ($urandom_range(0, 1) == 0) begin
				p = 0;
				l = $urandom_range(0, 15);
			end else begin
				p = $urandom_range(0, 15);
				l = 0;
			end
			t.position    = p[3:0];
			t.copy_length = l[3:0];
			t.literal     = 8'($urandom_range(0, 255));
			send_token(t, 1'b0, 0, 8'h00);
		end
		token_valid <= 1'b0;

		while (bytes_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (bytes_due.size() != 0)
			report("leftover bytes", 0, bytes_due.size());
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
